>>> rtl/prls_pkg.sv
package prls_pkg;

	localparam int MAX_TASKS_DEF = 8;

	localparam logic [2:0] MODE_ADD      = 3'd0;
	localparam logic [2:0] MODE_EXIT     = 3'd1;
	localparam logic [2:0] MODE_SCHEDULE = 3'd2;
	localparam logic [2:0] MODE_WAIT     = 3'd3;
	localparam logic [2:0] MODE_NOTIFY   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	// one task entry
	typedef struct packed {
		logic [7:0]  task_id;
		logic [7:0]  prio;
		logic        waiting;
		logic        sleeping;
		logic [31:0] data;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the request
		logic scan_init;  // pointer to top entry (count-1)
		logic scan_dec;   // pointer down by one
		logic scan_inc;   // pointer up by one
		logic shift_up;   // entry[ptr+1] <= entry[ptr]
		logic shift_down; // entry[ptr] <= entry[ptr+1]
		logic put_new;    // entry[ptr+1] <= new entry
		logic put_found;  // found index <= ptr
		logic mark_wait;  // update entry at found index for wait
		logic wake;       // clear sleep at ptr
		logic notify;     // release entry at ptr if matching
		logic cnt_inc;
		logic cnt_dec;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       full;
		logic       ptr_valid;  // pointer within list
		logic       ptr_last;   // pointer at count-1
		logic       prio_above; // entry[ptr].prio > new prio
		logic       id_match;   // entry[ptr].task_id == request id
		logic       runnable;   // entry[ptr] can be chosen
		logic       code_ok;
		logic       found;      // found index holds a hit
	} dp_stat_t;

endpackage

>>> rtl/priority_ready_list_scheduler.sv
// a request is dispatched, then the list is walked one slot a cycle; the longest request is
// an exit of the lowest entry of a full list (scan down to it, then shift the rest down)
// one request at a time: start is taken only while idle; busy drops in the cycle that carries done
// the result shows for one cycle with done; the receiver cannot stall
// reset: arst_n clears the entry count and the controller; slot contents stay undefined
module priority_ready_list_scheduler #(
	parameter int MAX_TASKS = prls_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [7:0]  task_id,
	input  logic [7:0]  priority_req,
	input  logic        start_sleeping,
	input  logic        start_waiting,
	input  logic [31:0] start_data,
	input  logic [31:0] now_tick,
	input  logic [31:0] reason,
	input  logic [31:0] given_code,
	input  logic [31:0] current_code,
	output logic        done,
	output logic [7:0]  chosen_task,
	output logic        chose_idle,
	output logic [1:0]  status,
	output logic        yield_request
);
	import prls_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [7:0] ptr_task;

	// controller walks the list one slot a cycle
	prls_ctrl u_ctrl (
		.clk, .arst_n, .start, .busy, .stat, .cmd, .ptr_task,
		.done, .chosen_task, .chose_idle, .status, .yield_request
	);

	// datapath holds the sorted entries and the scan pointer
	prls_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .mode, .task_id, .priority_req,
		.start_sleeping, .start_waiting, .start_data, .now_tick, .reason,
		.given_code, .current_code, .ptr_task
	);

endmodule

>>> rtl/prls_datapath.sv
module prls_datapath #(
	parameter int MAX_TASKS = prls_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prls_pkg::dp_cmd_t   cmd,
	output prls_pkg::dp_stat_t  stat,
	input  logic [2:0]          mode,
	input  logic [7:0]          task_id,
	input  logic [7:0]          priority_req,
	input  logic                start_sleeping,
	input  logic                start_waiting,
	input  logic [31:0]         start_data,
	input  logic [31:0]         now_tick,
	input  logic [31:0]         reason,
	input  logic [31:0]         given_code,
	input  logic [31:0]         current_code,
	output logic [7:0]          ptr_task
);
	import prls_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	// signed pointer: can go to -1 and up to MAX_TASKS-1
	localparam int PW = CW + 1;

	entry_t            slot_q [MAX_TASKS];
	logic [CW-1:0]     count_q;
	logic signed [PW-1:0] ptr_q;
	logic [IW-1:0]     found_q;
	logic              found_v_q;
	entry_t            new_q;
	logic [2:0]        mode_q;
	logic [31:0]       now_q;
	logic [31:0]       reason_q;
	logic              code_ok_q;

	logic [IW-1:0] pidx;
	logic [IW-1:0] pidx1;
	entry_t        cur;
	logic          in_range;

	assign in_range = (ptr_q >= 0) && (ptr_q < $signed({1'b0, count_q}));
	assign pidx  = ptr_q[IW-1:0];
	assign pidx1 = IW'(ptr_q + 1);
	assign cur   = slot_q[pidx];
	assign ptr_task = cur.task_id;

	always_comb begin
		stat.mode       = mode_q;
		stat.full       = (count_q >= CW'(MAX_TASKS));
		stat.ptr_valid  = in_range;
		stat.ptr_last   = (ptr_q == $signed({1'b0, count_q}) - 1);
		stat.prio_above = cur.prio > new_q.prio;
		stat.id_match   = cur.task_id == new_q.task_id;
		stat.runnable   = !cur.waiting && (!cur.sleeping || cur.data < now_q);
		stat.code_ok    = code_ok_q;
		stat.found      = found_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			found_v_q <= 1'b0;
			mode_q    <= '0;
		end else begin
			if (cmd.load) begin
				mode_q    <= mode;
				found_v_q <= 1'b0;
			end
			if (cmd.scan_init) ptr_q <= PW'($signed({1'b0, count_q}) - 1);
			else if (cmd.scan_dec) ptr_q <= PW'(ptr_q - 1);
			else if (cmd.scan_inc) ptr_q <= PW'(ptr_q + 1);
			if (cmd.put_found) found_v_q <= 1'b1;
			if (cmd.cnt_inc) count_q <= count_q + 1'b1;
			else if (cmd.cnt_dec) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q.task_id  <= task_id;
			new_q.prio     <= priority_req;
			new_q.waiting  <= start_waiting;
			new_q.sleeping <= start_sleeping;
			new_q.data     <= start_data;
			now_q          <= now_tick;
			reason_q       <= reason;
			code_ok_q      <= given_code == current_code;
		end
		if (cmd.put_found) found_q <= pidx;
		if (cmd.shift_up)   slot_q[pidx1] <= cur;
		if (cmd.put_new)    slot_q[pidx1] <= new_q;
		if (cmd.shift_down) slot_q[pidx]  <= slot_q[pidx1];
		if (cmd.wake)       slot_q[pidx].sleeping <= 1'b0;
		if (cmd.notify && cur.waiting && cur.data == reason_q) begin
			slot_q[pidx].waiting <= 1'b0;
			slot_q[pidx].data    <= '0;
		end
		if (cmd.mark_wait) begin
			slot_q[found_q].data     <= reason_q;
			slot_q[found_q].waiting  <= 1'b1;
			slot_q[found_q].sleeping <= 1'b0;
		end
	end

endmodule

>>> rtl/prls_ctrl.sv
module prls_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  prls_pkg::dp_stat_t stat,
	output prls_pkg::dp_cmd_t  cmd,
	input  logic [7:0]         ptr_task,
	output logic               done,
	output logic [7:0]         chosen_task,
	output logic               chose_idle,
	output logic [1:0]         status,
	output logic               yield_request
);
	import prls_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_ADD    = 3'd2;
	localparam logic [2:0] S_FIND   = 3'd3;
	localparam logic [2:0] S_CLOSE  = 3'd4;
	localparam logic [2:0] S_SCHED  = 3'd5;
	localparam logic [2:0] S_NOTIFY = 3'd6;
	localparam logic [2:0] S_WAITUP = 3'd7;

	logic [2:0] state_q, state_d;
	logic       done_d;
	logic [7:0] chosen_d;
	logic       idle_d, yield_d;
	logic [1:0] status_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		done_d   = 1'b0;
		chosen_d = '0;
		idle_d   = 1'b0;
		yield_d  = 1'b0;
		status_d = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.scan_init = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.mode)
					MODE_ADD: begin
						if (stat.full) begin
							status_d = ST_FULL;
							done_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_ADD;
						end
					end
					MODE_EXIT, MODE_WAIT: begin
						if (stat.mode == MODE_WAIT && !stat.code_ok) begin
							status_d = ST_MISMATCH;
							done_d = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_FIND;
						end
					end
					MODE_SCHEDULE: state_d = S_SCHED;
					MODE_NOTIFY: begin
						state_d = S_NOTIFY;
					end
					default: begin
						done_d = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_ADD: begin
				// walk down, moving higher-priority entries up one slot
				if (stat.ptr_valid && stat.prio_above) begin
					cmd.shift_up = 1'b1;
					cmd.scan_dec = 1'b1;
				end else begin
					cmd.put_new = 1'b1;
					cmd.cnt_inc = 1'b1;
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIND: begin
				if (!stat.ptr_valid) begin
					status_d = ST_NOT_FOUND;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else if (stat.id_match) begin
					cmd.put_found = 1'b1;
					state_d = (stat.mode == MODE_WAIT) ? S_WAITUP : S_CLOSE;
				end else begin
					cmd.scan_dec = 1'b1;
				end
			end
			S_CLOSE: begin
				if (stat.ptr_last) begin
					cmd.cnt_dec = 1'b1;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.shift_down = 1'b1;
					cmd.scan_inc = 1'b1;
				end
			end
			S_WAITUP: begin
				cmd.mark_wait = 1'b1;
				yield_d = 1'b1;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			S_SCHED: begin
				if (!stat.ptr_valid) begin
					idle_d = 1'b1;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else if (stat.runnable) begin
					cmd.wake = 1'b1;
					chosen_d = ptr_task;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.scan_dec = 1'b1;
				end
			end
			S_NOTIFY: begin
				if (!stat.ptr_valid) begin
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.notify = 1'b1;
					cmd.scan_dec = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		chosen_task   <= chosen_d;
		chose_idle    <= idle_d;
		status        <= status_d;
		yield_request <= yield_d;
	end

endmodule
